>>> rtl/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;

	// Default table depth, one entry per station
	localparam int NUM_STATIONS_DEF = 32;

	localparam logic [7:0] SEQ_MAX       = 8'd254;
	localparam logic [7:0] SEQ_NONE      = 8'd255;
	localparam logic [7:0] SEQ_RESET     = 8'd0;
	localparam logic [7:0] MIN_LEN_RESET = 8'd5;

	// Item modes
	localparam logic [1:0] MODE_TX_QUERY = 2'd0;
	localparam logic [1:0] MODE_TX_DONE  = 2'd1;
	localparam logic [1:0] MODE_RX       = 2'd2;

	// Configuration register indexes
	localparam logic CFG_ENABLE  = 1'b0;
	localparam logic CFG_MIN_LEN = 1'b1;

	typedef enum logic [2:0] {
		V_OK        = 3'd0,
		V_STRIPPED  = 3'd1,
		V_WHOLE     = 3'd2,
		V_SHORT     = 3'd3,
		V_UNKNOWN   = 3'd4,
		V_DUP       = 3'd5,
		V_NOT_READY = 3'd6
	} verdict_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

endpackage
`default_nettype wire

>>> rtl/per_station_sequence_dedup.sv
`timescale 1ns / 1ps
`default_nettype none
// The item and the table read are registered on accept; done and the result are registered from the execute state.
// Each item is a table read, then decide-and-write; no new item is taken while busy.
// busy is high for the one cycle the table read data is evaluated.
// Results cannot be stalled: done is a single-cycle strobe.
// Reset: async, active low; tables read as reset values at once, no clearing pass.
module per_station_sequence_dedup #(
	parameter int NUM_STATIONS = psd_pkg::NUM_STATIONS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_addr,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] station,
	input  wire logic       is_broadcast,
	input  wire logic       acked,
	input  wire logic [7:0] seq_in,
	input  wire logic [7:0] frame_len,
	output logic            done,
	output logic      [7:0] seq_out,
	output logic            add_seq,
	output logic      [2:0] verdict
);

	localparam int IDX_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;

	psd_pkg::state_t state_q, state_nx;

	logic             enable_q;
	logic [7:0]       min_len_q;
	logic             accept;
	logic             known;

	logic [1:0]       mode_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             known_s1;
	logic             bcast_s1;
	logic             acked_s1;
	logic [7:0]       seq_s1;
	logic [7:0]       len_s1;

	logic [7:0]       next_rd;
	logic [7:0]       last_rd;
	logic             next_we;
	logic [7:0]       next_wd;
	logic             last_we;

	logic [7:0]          res_seq;
	logic                res_add;
	psd_pkg::verdict_t   res_verdict;

	logic                done_q;
	logic [7:0]          seq_out_q;
	logic                add_seq_q;
	psd_pkg::verdict_t   verdict_q;

	assign accept = start && !busy;
	assign known  = station < 8'(NUM_STATIONS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			min_len_q <= psd_pkg::MIN_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				psd_pkg::CFG_ENABLE:  enable_q  <= cfg_wdata[0];
				psd_pkg::CFG_MIN_LEN: min_len_q <= cfg_wdata;
				default:              enable_q  <= enable_q;
			endcase
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			idx_s1   <= station[IDX_W-1:0];
			known_s1 <= known;
			bcast_s1 <= is_broadcast;
			acked_s1 <= acked;
			seq_s1   <= seq_in;
			len_s1   <= frame_len;
		end
	end

	// Tables; read issued on accept, written in the execute cycle
	psd_table #(
		.DEPTH   (NUM_STATIONS),
		.IDX_W   (IDX_W),
		.RST_VAL (psd_pkg::SEQ_RESET)
	) u_next_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && known),
		.rd_addr (station[IDX_W-1:0]),
		.rd_data (next_rd),
		.wr_en   (next_we),
		.wr_addr (idx_s1),
		.wr_data (next_wd)
	);

	psd_table #(
		.DEPTH   (NUM_STATIONS),
		.IDX_W   (IDX_W),
		.RST_VAL (psd_pkg::SEQ_NONE)
	) u_last_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && known),
		.rd_addr (station[IDX_W-1:0]),
		.rd_data (last_rd),
		.wr_en   (last_we),
		.wr_addr (idx_s1),
		.wr_data (seq_s1)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and busy
	always_comb begin
		state_nx = state_q;
		busy     = 1'b0;
		case (state_q)
			psd_pkg::ST_IDLE: begin
				if (start) begin
					state_nx = psd_pkg::ST_EXEC;
				end
			end
			psd_pkg::ST_EXEC: begin
				busy     = 1'b1;
				state_nx = psd_pkg::ST_IDLE;
			end
			default: state_nx = psd_pkg::ST_IDLE;
		endcase
	end

	// Decision and write-back
	always_comb begin
		res_seq     = 8'd0;
		res_add     = 1'b0;
		res_verdict = psd_pkg::V_OK;
		next_we     = 1'b0;
		next_wd     = (next_rd >= psd_pkg::SEQ_MAX) ? 8'd0 : next_rd + 8'd1;
		last_we     = 1'b0;
		case (mode_s1)
			psd_pkg::MODE_TX_QUERY: begin
				if (!enable_q) begin
					res_verdict = psd_pkg::V_NOT_READY;
				end else if (!bcast_s1) begin
					res_seq = known_s1 ? next_rd : psd_pkg::SEQ_NONE;
					res_add = 1'b1;
				end
			end
			psd_pkg::MODE_TX_DONE: begin
				if (!enable_q) begin
					res_verdict = psd_pkg::V_NOT_READY;
				end else begin
					next_we = busy && acked_s1 && !bcast_s1 && known_s1;
				end
			end
			psd_pkg::MODE_RX: begin
				if (len_s1 <= min_len_q) begin
					res_verdict = psd_pkg::V_SHORT;
				end else if (bcast_s1) begin
					res_verdict = psd_pkg::V_WHOLE;
				end else if (!known_s1) begin
					res_verdict = psd_pkg::V_UNKNOWN;
				end else if (seq_s1 == last_rd) begin
					res_verdict = psd_pkg::V_DUP;
				end else begin
					res_verdict = psd_pkg::V_STRIPPED;
					last_we     = busy && (seq_s1 != psd_pkg::SEQ_NONE);
				end
			end
			default: res_verdict = psd_pkg::V_NOT_READY;
		endcase
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (busy) begin
			seq_out_q <= res_seq;
			add_seq_q <= res_add;
			verdict_q <= res_verdict;
		end
	end

	assign done    = done_q;
	assign seq_out = seq_out_q;
	assign add_seq = add_seq_q;
	assign verdict = verdict_q;

endmodule
`default_nettype wire

>>> rtl/psd_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-station table: synchronous memory with registered read.
// Valid bits cleared at reset make unwritten entries read as RST_VAL.
module psd_table #(
	parameter int         DEPTH   = psd_pkg::NUM_STATIONS_DEF,
	parameter int         IDX_W   = 5,
	parameter logic [7:0] RST_VAL = 8'd0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [7:0]       rd_data,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic [7:0]       wr_data
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       data_q;
	logic             vld_q;

	// Storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
			vld_q  <= valid_q[rd_addr];
		end
	end

	// Entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = vld_q ? data_q : RST_VAL;

endmodule
`default_nettype wire

>>> bench/per_station_sequence_dedup_test.sv
`timescale 1ns / 1ps
module per_station_sequence_dedup_test;
	import psd_pkg::*;

	localparam int NUM_ST = NUM_STATIONS_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PROF_MIXED = 0;
	localparam int PROF_WRAP = 1;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] station;
		logic       bcast;
		logic       acked;
		logic [7:0] seq;
		logic [7:0] len;
	} item_t;

	typedef struct packed {
		logic [7:0] seq_out;
		logic       add_seq;
		verdict_t   verdict;
	} outcome_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_addr = CFG_ENABLE;
	logic [7:0] cfg_wdata = 8'd0;
	logic       start = 1'b0;
	logic [1:0] mode = MODE_TX_QUERY;
	logic [7:0] station = 8'd0;
	logic       is_broadcast = 1'b0;
	logic       acked = 1'b0;
	logic [7:0] seq_in = 8'd0;
	logic [7:0] frame_len = 8'd0;
	logic       busy;
	logic       done;
	logic [7:0] seq_out;
	logic       add_seq;
	logic [2:0] verdict;

	// Shadow of the block's tables and registers
	logic [7:0] tx_next [NUM_ST];
	logic [7:0] rx_last [NUM_ST];
	logic       cfg_enable;
	logic [7:0] cfg_min_len;

	// Generator's guess at the last received number, to provoke duplicates
	logic [7:0] gen_last [NUM_ST];

	item_t    station_ops_q [$];
	outcome_t due_outcomes [$];
	int       fail_count = 0;
	int       cycle_count = 0;
	int       gap_left = 0;
	int       no_gap_run = 0;

	int ph_enable [6] = '{1, 1, 0, 1, 1, 0};
	int ph_min    [6] = '{8, 3, 255, 0, 255, 12};
	int ph_count  [6] = '{450, 520, 120, 450, 100, 60};
	int ph_prof   [6] = '{PROF_MIXED, PROF_WRAP, PROF_MIXED, PROF_MIXED, PROF_MIXED, PROF_MIXED};

	per_station_sequence_dedup DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.mode(mode),
		.station(station),
		.is_broadcast(is_broadcast),
		.acked(acked),
		.seq_in(seq_in),
		.frame_len(frame_len),
		.done(done),
		.seq_out(seq_out),
		.add_seq(add_seq),
		.verdict(verdict)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Work out the outcome of one item and update the shadow tables
	function automatic outcome_t judge_item(logic [1:0] m, logic [7:0] st, logic bc,
			logic ak, logic [7:0] sq, logic [7:0] len);
		outcome_t r;
		logic     known;
		r.seq_out = 8'd0;
		r.add_seq = 1'b0;
		r.verdict = V_OK;
		known = (st < NUM_ST);
		case (m)
		MODE_TX_QUERY: begin
			if (!cfg_enable)
				r.verdict = V_NOT_READY;
			else if (!bc) begin
				r.add_seq = 1'b1;
				r.seq_out = known ? tx_next[st] : SEQ_NONE;
			end
		end
		MODE_TX_DONE: begin
			if (!cfg_enable)
				r.verdict = V_NOT_READY;
			else if (ak && !bc && known)
				tx_next[st] = (tx_next[st] >= SEQ_MAX) ? SEQ_RESET : tx_next[st] + 8'd1;
		end
		MODE_RX: begin
			if (len <= cfg_min_len)
				r.verdict = V_SHORT;
			else if (bc)
				r.verdict = V_WHOLE;
			else if (!known)
				r.verdict = V_UNKNOWN;
			else if (sq == rx_last[st])
				r.verdict = V_DUP;
			else begin
				// a received 255 is never stored
				if (sq != SEQ_NONE)
					rx_last[st] = sq;
				r.verdict = V_STRIPPED;
			end
		end
		default: r.verdict = V_NOT_READY;
		endcase
		return r;
	endfunction

	function automatic item_t mk_item(logic [1:0] m, logic [7:0] st, logic bc, logic ak,
			logic [7:0] sq, logic [7:0] len);
		item_t it;
		it.mode = m;
		it.station = st;
		it.bcast = bc;
		it.acked = ak;
		it.seq = sq;
		it.len = len;
		return it;
	endfunction

	// Random item; the wrap profile hammers station 0 with acknowledged sends
	function automatic item_t rand_item(int profile);
		item_t it;
		int    pick;
		pick = $urandom_range(0, 99);
		if (profile == PROF_WRAP)
			it.mode = (pick < 15) ? MODE_TX_QUERY : (pick < 95) ? MODE_TX_DONE : MODE_RX;
		else
			it.mode = (pick < 30) ? MODE_TX_QUERY : (pick < 60) ? MODE_TX_DONE :
				(pick < 98) ? MODE_RX : MODE_UNUSED;
		pick = $urandom_range(0, 99);
		if (profile == PROF_WRAP)
			it.station = (pick < 90) ? 8'd0 : 8'($urandom_range(0, 255));
		else
			it.station = (pick < 50) ? 8'($urandom_range(0, 3)) :
				(pick < 75) ? 8'($urandom_range(0, NUM_ST - 1)) : 8'($urandom_range(0, 255));
		it.bcast = ($urandom_range(0, 99) < ((profile == PROF_WRAP) ? 5 : 15));
		it.acked = ($urandom_range(0, 9) < ((profile == PROF_WRAP) ? 9 : 7));
		pick = $urandom_range(0, 9);
		if (pick < 4 && it.station < NUM_ST)
			it.seq = gen_last[it.station];
		else if (pick == 4)
			it.seq = SEQ_NONE;
		else if (pick == 5)
			it.seq = 8'd0;
		else
			it.seq = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
		0: it.len = 8'($urandom_range(0, 255));
		1: it.len = cfg_min_len;
		default: it.len = (cfg_min_len > 8'd250) ? 8'd255 :
			cfg_min_len + 8'd1 + 8'($urandom_range(0, 4));
		endcase
		if (it.mode == MODE_RX && it.station < NUM_ST && it.seq != SEQ_NONE)
			gen_last[it.station] = it.seq;
		return it;
	endfunction

	function automatic int draw_gap();
		if (no_gap_run > 0) begin
			no_gap_run--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			no_gap_run = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	// Item driver: take from the queue, hold start until the block takes the item
	always @(posedge clk) begin : item_driver
		item_t nxt;
		logic  taken;
		taken = arst_n && start && !busy;
		if (taken) begin
			due_outcomes.push_back(judge_item(mode, station, is_broadcast, acked,
				seq_in, frame_len));
			gap_left = draw_gap();
		end
		if (taken || !start) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (station_ops_q.size() != 0) begin
				nxt = station_ops_q.pop_front();
				mode <= nxt.mode;
				station <= nxt.station;
				is_broadcast <= nxt.bcast;
				acked <= nxt.acked;
				seq_in <= nxt.seq;
				frame_len <= nxt.len;
				start <= 1'b1;
			end else
				start <= 1'b0;
		end
	end

	// Result monitor: each strobe is matched against the oldest outcome due
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			if (due_outcomes.size() == 0) begin
				$error("result with no item outstanding: seq_out %0d add_seq %0d verdict %0d",
					seq_out, add_seq, verdict);
				fail_count++;
			end else begin
				want = due_outcomes.pop_front();
				if (seq_out !== want.seq_out) begin
					$error("seq_out: expected %0d, got %0d", want.seq_out, seq_out);
					fail_count++;
				end
				if (add_seq !== want.add_seq) begin
					$error("add_seq: expected %0d, got %0d", want.add_seq, add_seq);
					fail_count++;
				end
				if (verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, verdict);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic wait_idle();
		do
			@(negedge clk);
		while (station_ops_q.size() != 0 || start || due_outcomes.size() != 0);
	endtask

	task automatic cfg_write(logic idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ENABLE)
			cfg_enable = val[0];
		else
			cfg_min_len = val;
	endtask

	initial begin
		for (int i = 0; i < NUM_ST; i++) begin
			tx_next[i] = SEQ_RESET;
			rx_last[i] = SEQ_NONE;
			gen_last[i] = SEQ_NONE;
		end
		cfg_enable = 1'b0;
		cfg_min_len = MIN_LEN_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: link not ready, receive still filtered
		station_ops_q.push_back(mk_item(MODE_TX_QUERY, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_DONE, 8'd0, 1'b0, 1'b1, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd2, 1'b0, 1'b0, 8'd9, 8'd5));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd2, 1'b0, 1'b0, 8'd9, 8'd6));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd2, 1'b0, 1'b0, 8'd9, 8'd6));
		station_ops_q.push_back(mk_item(MODE_UNUSED, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255));
		wait_idle();

		cfg_write(CFG_ENABLE, 8'd1);
		cfg_write(CFG_MIN_LEN, 8'd0);
		@(negedge clk);

		// Transmit side: numbering, broadcast, out-of-range stations
		station_ops_q.push_back(mk_item(MODE_TX_QUERY, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_DONE, 8'd0, 1'b0, 1'b1, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_QUERY, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_DONE, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_DONE, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_DONE, 8'd200, 1'b0, 1'b1, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_QUERY, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_QUERY, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_TX_QUERY, 8'd32, 1'b0, 1'b0, 8'd0, 8'd0));
		// Receive side: short, broadcast, unknown, duplicate, 255 never stored
		station_ops_q.push_back(mk_item(MODE_RX, 8'd1, 1'b0, 1'b0, 8'd3, 8'd0));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd1, 1'b1, 1'b0, 8'd3, 8'd1));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd32, 1'b0, 1'b0, 8'd3, 8'd255));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd31, 1'b0, 1'b0, 8'd255, 8'd9));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd31, 1'b0, 1'b0, 8'd0, 8'd9));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd31, 1'b0, 1'b0, 8'd255, 8'd9));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd31, 1'b0, 1'b0, 8'd0, 8'd9));
		station_ops_q.push_back(mk_item(MODE_UNUSED, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0));
		station_ops_q.push_back(mk_item(MODE_RX, 8'd255, 1'b0, 1'b1, 8'd128, 8'd200));

		// Random phases, each under its own register settings
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			cfg_write(CFG_ENABLE, 8'(ph_enable[p]));
			cfg_write(CFG_MIN_LEN, 8'(ph_min[p]));
			@(negedge clk);
			for (int n = 0; n < ph_count[p]; n++)
				station_ops_q.push_back(rand_item(ph_prof[p]));
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && due_outcomes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
